### rtl/core/pklfu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pklfu_pkg: shared types and constants for the pair-key LFU cache
// Widths of the request and result fields, reset values, the layout of one
// cache entry and the saturating count update.
// ----------------------------------------------------------------------------
package pklfu_pkg;

    localparam int KEY_W      = 32;
    localparam int COUNT_W    = 32;
    localparam int BONUS_W    = 8;
    localparam int SLOT_OUT_W = 4;
    localparam int DEF_SLOTS  = 16;

    localparam logic [BONUS_W-1:0] BONUS_RESET = 8'd5;
    localparam logic [COUNT_W-1:0] FIRST_USE   = 32'd1;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [KEY_W-1:0]   src;
        logic [KEY_W-1:0]   tgt;
        logic [COUNT_W-1:0] uses;
    } t_entry;

    // Adds a small increment to a use count, sticking at the maximum.
    function automatic logic [COUNT_W-1:0] sat_add(
        input logic [COUNT_W-1:0] a,
        input logic [BONUS_W-1:0] b
    );
        logic [COUNT_W:0] sum;
        sum = {1'b0, a} + (COUNT_W + 1)'(b);
        return sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/core/pair_key_lfu_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pair_key_lfu_cache: pair-keyed cache with least-frequently-used replacement
// An item scans its filled slots one per cycle through the single memory
// read port; the result strobe is registered when the scan ends, at the hit
// slot or after all filled slots on a miss. When the cache is empty the
// strobe rises at the accepting edge itself and busy stays low. Busy stays
// high through the scan, so a new item is taken only once the last one is
// through. The receiver cannot stall. Reset empties the cache (fill count
// zero, no clearing pass) and sets the eviction bonus
// to 5.
// ----------------------------------------------------------------------------
module pair_key_lfu_cache #(
    parameter int SLOTS = pklfu_pkg::DEF_SLOTS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [pklfu_pkg::BONUS_W-1:0]       i_cfg_data,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [pklfu_pkg::KEY_W-1:0]  i_source_key,
    input  wire logic signed [pklfu_pkg::KEY_W-1:0]  i_target_key,
    output logic                                     o_done,
    output logic                                     o_was_hit,
    output logic [pklfu_pkg::SLOT_OUT_W-1:0]         o_slot_index,
    output logic [pklfu_pkg::COUNT_W-1:0]            o_use_count,
    output logic                                     o_did_evict,
    output logic signed [pklfu_pkg::KEY_W-1:0]       o_evicted_source,
    output logic signed [pklfu_pkg::KEY_W-1:0]       o_evicted_target
);
    import pklfu_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int FW = $clog2(SLOTS + 1);
    localparam logic [FW-1:0] FULL = FW'(SLOTS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    // Entry memory: one write port, one registered read port
    t_entry            r_mem [SLOTS];
    t_entry            r_rd_data;
    logic [IW-1:0]     rd_addr;
    logic              mem_we;
    logic [IW-1:0]     mem_wa;
    t_entry            mem_wd;

    logic              r_state, n_state;
    logic [FW-1:0]     r_filled, n_filled;
    logic [BONUS_W-1:0] r_bonus;
    logic [IW-1:0]     r_idx, n_idx;
    logic [KEY_W-1:0]  r_src, n_src;
    logic [KEY_W-1:0]  r_tgt, n_tgt;

    // Running minimum over the slots scanned so far
    logic [COUNT_W-1:0] r_low, n_low;
    logic [IW-1:0]      r_low_idx, n_low_idx;
    logic [KEY_W-1:0]   r_low_src, n_low_src;
    logic [KEY_W-1:0]   r_low_tgt, n_low_tgt;

    logic               r_done, n_done;
    logic               r_hit, n_hit;
    logic [SLOT_OUT_W-1:0] r_slot, n_slot;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_evict, n_evict;
    logic [KEY_W-1:0]   r_ev_src, n_ev_src;
    logic [KEY_W-1:0]   r_ev_tgt, n_ev_tgt;

    logic               accept;
    logic               match;
    logic               lower;
    logic               last;
    logic [COUNT_W-1:0] cur_low;
    logic [IW-1:0]      cur_idx;
    logic [KEY_W-1:0]   cur_src;
    logic [KEY_W-1:0]   cur_tgt;
    logic [COUNT_W-1:0] new_count;

    assign busy   = (r_state == S_SCAN);
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Compare and minimum tracking on the entry read last cycle
    always_comb begin
        match   = (r_rd_data.src == r_src) && (r_rd_data.tgt == r_tgt);
        lower   = (r_idx == '0) || (r_rd_data.uses < r_low);
        cur_low = lower ? r_rd_data.uses : r_low;
        cur_idx = lower ? r_idx : r_low_idx;
        cur_src = lower ? r_rd_data.src : r_low_src;
        cur_tgt = lower ? r_rd_data.tgt : r_low_tgt;
        last    = ((FW'(r_idx) + FW'(1)) == r_filled);
    end

    always_comb begin
        n_state   = r_state;
        n_filled  = r_filled;
        n_idx     = r_idx;
        n_src     = r_src;
        n_tgt     = r_tgt;
        n_low     = r_low;
        n_low_idx = r_low_idx;
        n_low_src = r_low_src;
        n_low_tgt = r_low_tgt;
        n_done    = 1'b0;
        n_hit     = r_hit;
        n_slot    = r_slot;
        n_count   = r_count;
        n_evict   = r_evict;
        n_ev_src  = r_ev_src;
        n_ev_tgt  = r_ev_tgt;
        rd_addr   = '0;
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = '0;
        new_count = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_src = i_source_key;
                    n_tgt = i_target_key;
                    n_idx = '0;
                    if (r_filled == '0) begin
                        // Empty cache: the pair goes straight into slot zero
                        mem_we   = 1'b1;
                        mem_wa   = '0;
                        mem_wd   = '{src: i_source_key, tgt: i_target_key, uses: FIRST_USE};
                        n_filled = FW'(1);
                        n_done   = 1'b1;
                        n_hit    = 1'b0;
                        n_slot   = '0;
                        n_count  = FIRST_USE;
                        n_evict  = 1'b0;
                        n_ev_src = '0;
                        n_ev_tgt = '0;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                rd_addr   = r_idx + IW'(1);
                n_low     = cur_low;
                n_low_idx = cur_idx;
                n_low_src = cur_src;
                n_low_tgt = cur_tgt;
                if (match) begin
                    new_count = sat_add(r_rd_data.uses, BONUS_W'(1));
                    mem_we    = 1'b1;
                    mem_wa    = r_idx;
                    mem_wd    = '{src: r_src, tgt: r_tgt, uses: new_count};
                    n_state   = S_IDLE;
                    n_done    = 1'b1;
                    n_hit     = 1'b1;
                    n_slot    = SLOT_OUT_W'(r_idx);
                    n_count   = new_count;
                    n_evict   = 1'b0;
                    n_ev_src  = '0;
                    n_ev_tgt  = '0;
                end else if (last) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    n_hit   = 1'b0;
                    mem_we  = 1'b1;
                    if (r_filled == FULL) begin
                        // Full miss: replace the least used slot, lowest index on ties
                        new_count = sat_add(cur_low, r_bonus);
                        mem_wa    = cur_idx;
                        mem_wd    = '{src: r_src, tgt: r_tgt, uses: new_count};
                        n_slot    = SLOT_OUT_W'(cur_idx);
                        n_count   = new_count;
                        n_evict   = 1'b1;
                        n_ev_src  = cur_src;
                        n_ev_tgt  = cur_tgt;
                    end else begin
                        mem_wa   = r_filled[IW-1:0];
                        mem_wd   = '{src: r_src, tgt: r_tgt, uses: FIRST_USE};
                        n_filled = r_filled + FW'(1);
                        n_slot   = SLOT_OUT_W'(r_filled[IW-1:0]);
                        n_count  = FIRST_USE;
                        n_evict  = 1'b0;
                        n_ev_src = '0;
                        n_ev_tgt = '0;
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_filled <= '0;
            r_bonus  <= BONUS_RESET;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_filled <= n_filled;
            r_done   <= n_done;
            if (i_cfg_we) begin
                r_bonus <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_src     <= n_src;
        r_tgt     <= n_tgt;
        r_low     <= n_low;
        r_low_idx <= n_low_idx;
        r_low_src <= n_low_src;
        r_low_tgt <= n_low_tgt;
        r_hit     <= n_hit;
        r_slot    <= n_slot;
        r_count   <= n_count;
        r_evict   <= n_evict;
        r_ev_src  <= n_ev_src;
        r_ev_tgt  <= n_ev_tgt;
    end

    assign o_done           = r_done;
    assign o_was_hit        = r_hit;
    assign o_slot_index     = r_slot;
    assign o_use_count      = r_count;
    assign o_did_evict      = r_evict;
    assign o_evicted_source = r_ev_src;
    assign o_evicted_target = r_ev_tgt;

    // An accepted beat either completes at once or starts a scan.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_done || busy))
        else $error("accepted beat neither completed nor started a scan");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= FULL)
        else $error("fill count beyond the number of slots");

    // Eviction only ever happens on a miss with every slot taken.
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_did_evict) |-> (!o_was_hit && r_filled == FULL))
        else $error("eviction reported without a full-cache miss");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_was_hit && !o_did_evict) |-> (o_use_count == FIRST_USE))
        else $error("free-slot insert with a count other than one");

endmodule
`default_nettype wire

### tb/pair_key_lfu_cache_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pair_key_lfu_cache_tb: self-checking bench for the pair-key LFU cache
// Requests go in through the start/busy handshake. A mirror of the cache
// predicts hit or insert, the slot, the use count and any eviction for each
// request. Every result beat is then checked against the oldest prediction.
// The run opens with a directed fill and eviction sequence. It then works
// through several eviction bonus settings with random traffic drawn mostly
// from a pool of key pairs.
// ----------------------------------------------------------------------------
module pair_key_lfu_cache_tb;
    import pklfu_pkg::*;

    localparam int SLOTS       = DEF_SLOTS;
    localparam int PHASE_ITEMS = 205;
    localparam int POOL_SIZE   = 28;
    localparam int HOT_SIZE    = 6;
    localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef struct {
        logic                  was_hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic [COUNT_W-1:0]    uses;
        logic                  did_evict;
        logic [KEY_W-1:0]      ev_src;
        logic [KEY_W-1:0]      ev_tgt;
    } t_outcome;

    class cache_mirror;
        logic [KEY_W-1:0]   slot_src  [SLOTS];
        logic [KEY_W-1:0]   slot_tgt  [SLOTS];
        logic [COUNT_W-1:0] slot_uses [SLOTS];
        int                 filled;
        logic [BONUS_W-1:0] bonus;
        t_outcome           pending[$];
        int                 errors;

        function new();
            filled = 0;
            bonus  = BONUS_RESET;
            errors = 0;
        endfunction

        function void set_bonus(logic [BONUS_W-1:0] value);
            bonus = value;
        endfunction

        function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] a, logic [BONUS_W-1:0] b);
            logic [COUNT_W-1:0] step;
            step = COUNT_W'(b);
            return (a > COUNT_MAX - step) ? COUNT_MAX : a + step;
        endfunction

        // Updates the mirror for one accepted request and queues its outcome.
        function void note_request(logic [KEY_W-1:0] src, logic [KEY_W-1:0] tgt);
            t_outcome want;
            int       hit_at;
            int       victim;
            hit_at = -1;
            victim = 0;
            want   = '{default: '0};
            for (int i = 0; i < filled; i++) begin
                if (hit_at < 0 && slot_src[i] == src && slot_tgt[i] == tgt)
                    hit_at = i;
            end
            if (hit_at >= 0) begin
                slot_uses[hit_at] = bump(slot_uses[hit_at], 8'd1);
                want.was_hit = 1'b1;
                want.slot    = hit_at[SLOT_OUT_W-1:0];
                want.uses    = slot_uses[hit_at];
            end else begin
                if (filled < SLOTS) begin
                    victim    = filled;
                    filled++;
                    want.uses = FIRST_USE;
                end else begin
                    // Strict comparison keeps the lowest index on a tie.
                    for (int i = 1; i < SLOTS; i++) begin
                        if (slot_uses[i] < slot_uses[victim])
                            victim = i;
                    end
                    want.did_evict = 1'b1;
                    want.ev_src    = slot_src[victim];
                    want.ev_tgt    = slot_tgt[victim];
                    want.uses      = bump(slot_uses[victim], bonus);
                end
                want.slot         = victim[SLOT_OUT_W-1:0];
                slot_src[victim]  = src;
                slot_tgt[victim]  = tgt;
                slot_uses[victim] = want.uses;
            end
            pending.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_outcome(t_outcome got);
            t_outcome want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result beat with no request outstanding (slot %0d)",
                         $time, got.slot);
                return;
            end
            want = pending.pop_front();
            compare_field("was_hit", 32'(want.was_hit), 32'(got.was_hit));
            compare_field("slot_index", 32'(want.slot), 32'(got.slot));
            compare_field("use_count", want.uses, got.uses);
            compare_field("did_evict", 32'(want.did_evict), 32'(got.did_evict));
            compare_field("evicted_source", want.ev_src, got.ev_src);
            compare_field("evicted_target", want.ev_tgt, got.ev_tgt);
        endfunction
    endclass

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [BONUS_W-1:0]    i_cfg_data   = '0;
    logic                  start        = 1'b0;
    logic [KEY_W-1:0]      i_source_key = '0;
    logic [KEY_W-1:0]      i_target_key = '0;
    logic                  busy;
    logic                  o_done;
    logic                  o_was_hit;
    logic [SLOT_OUT_W-1:0] o_slot_index;
    logic [COUNT_W-1:0]    o_use_count;
    logic                  o_did_evict;
    logic [KEY_W-1:0]      o_evicted_source;
    logic [KEY_W-1:0]      o_evicted_target;

    logic [KEY_W-1:0] pool_src [POOL_SIZE];
    logic [KEY_W-1:0] pool_tgt [POOL_SIZE];

    cache_mirror mirror = new();

    pair_key_lfu_cache dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .start            (start),
        .busy             (busy),
        .i_source_key     (i_source_key),
        .i_target_key     (i_target_key),
        .o_done           (o_done),
        .o_was_hit        (o_was_hit),
        .o_slot_index     (o_slot_index),
        .o_use_count      (o_use_count),
        .o_did_evict      (o_did_evict),
        .o_evicted_source (o_evicted_source),
        .o_evicted_target (o_evicted_target)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin : watch_results
        t_outcome seen;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            seen.was_hit   = o_was_hit;
            seen.slot      = o_slot_index;
            seen.uses      = o_use_count;
            seen.did_evict = o_did_evict;
            seen.ev_src    = o_evicted_source;
            seen.ev_tgt    = o_evicted_target;
            mirror.check_outcome(seen);
        end
    end

    // Start stays high from one beat to the next unless a gap follows.
    task automatic send_request(logic [KEY_W-1:0] src, logic [KEY_W-1:0] tgt);
        start        <= 1'b1;
        i_source_key <= src;
        i_target_key <= tgt;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        mirror.note_request(src, tgt);
    endtask

    task automatic pause(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (mirror.pending.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 2) @(posedge i_clk);
    endtask

    task automatic write_bonus(logic [BONUS_W-1:0] value);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        mirror.set_bonus(value);
    endtask

    function automatic logic [KEY_W-1:0] fresh_key();
        case ($urandom_range(0, 15))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(int items, bit may_idle);
        logic [KEY_W-1:0] src;
        logic [KEY_W-1:0] tgt;
        int               pick;
        int               roll;
        int               calm_left;
        calm_left = 0;
        // Part of the pool is renewed so that each phase brings new pairs in.
        for (int i = 0; i < POOL_SIZE; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                pool_src[i] = (i > 0 && $urandom_range(0, 3) == 0) ? pool_src[i-1]
                                                                    : fresh_key();
                pool_tgt[i] = fresh_key();
            end
        end
        for (int n = 0; n < items; n++) begin
            roll = $urandom_range(0, 99);
            pick = (roll < 40) ? $urandom_range(0, HOT_SIZE - 1)
                               : $urandom_range(0, POOL_SIZE - 1);
            src  = pool_src[pick];
            tgt  = pool_tgt[pick];
            if (roll >= 80 && roll < 86) begin
                tgt = $urandom;
            end else if (roll >= 86 && roll < 90) begin
                src = $urandom;
            end else if (roll >= 90) begin
                src = fresh_key();
                tgt = fresh_key();
            end
            if (may_idle) begin
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 39) == 0)
                    calm_left = $urandom_range(10, 40);
                else if ($urandom_range(0, 2) == 0)
                    pause($urandom_range(1, 18));
            end
            send_request(src, tgt);
        end
    endtask

    initial begin : stimulus
        logic [BONUS_W-1:0] bonus_plan [5];
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_src[i] = fresh_key();
            pool_tgt[i] = fresh_key();
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run with the bonus left at its reset value.
        send_request('0, '0);
        send_request('0, '0);
        send_request(KEY_MIN, KEY_MAX);
        send_request(KEY_MAX, KEY_MIN);
        send_request('1, '1);
        send_request('0, '1);
        send_request('1, '0);
        send_request(KEY_MIN, KEY_MIN);
        send_request(KEY_MAX, KEY_MAX);
        for (int i = 1; i <= 8; i++)
            send_request(i, -i);
        send_request(KEY_MAX, KEY_MAX);
        send_request(KEY_MIN, KEY_MAX);
        send_request('0, '0);
        // The cache is full now, so each new pair evicts the least used entry.
        send_request(32'h1234_5678, 32'h8765_4321);
        send_request(32'h8765_4321, 32'h1234_5678);
        send_request(32'h1234_5678, 32'h8765_4321);
        send_request(KEY_MAX, KEY_MIN);

        bonus_plan = '{8'd0, 8'd255, 8'($urandom_range(2, 254)), 8'd1, BONUS_RESET};
        for (int p = 0; p < 5; p++) begin
            write_bonus(bonus_plan[p]);
            run_phase(PHASE_ITEMS, p < 4);
        end
        settle();

        if (mirror.errors == 0 && mirror.pending.size() == 0)
            $display("pair_key_lfu_cache_tb: clean");
        else
            $display("pair_key_lfu_cache_tb: errors");
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("pair_key_lfu_cache_tb: errors");
        $finish;
    end

endmodule
`default_nettype wire
